/* hdl/i2cms_pkg.sv */
// shared types and codes for the i2c master byte sequencer
// used by i2cms_core, i2cms_out and i2c_master_byte_sequencer; no dependencies
package i2cms_pkg;

  // command codes carried by each input item
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_STOP   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_RD_ACK = 3'd4,
    OP_RD_NAK = 3'd5
  } op_e;

  // command in progress
  typedef enum logic [2:0] {
    KIND_IDLE   = 3'd0,
    KIND_START  = 3'd1,
    KIND_STOP   = 3'd2,
    KIND_WRITE  = 3'd3,
    KIND_RD_ACK = 3'd4,
    KIND_RD_NAK = 3'd5
  } kind_e;

  localparam int unsigned OpW       = 3;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned PhaseW    = 2;
  localparam int unsigned BitCntW   = 4;
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 16;
  localparam logic [BitCntW-1:0] LastBit = 4'd8;

  // phase step codes
  localparam logic [PhaseW-1:0] PhaseLow  = 2'd0;
  localparam logic [PhaseW-1:0] PhaseHigh = 2'd1;
  localparam logic [PhaseW-1:0] PhaseTail = 2'd2;

  // one result item
  typedef struct packed {
    logic             cmd_rejected;
    logic [ByteW-1:0] read_byte;
    logic             ack_ok;
    logic             done_res;
    logic             busy_res;
    logic             sda_out;
    logic             scl_out;
  } res_t;

endpackage

/* hdl/i2cms_core.sv */
// sequencer state and the single-pass next-state logic for one item
// depends on i2cms_pkg
module i2cms_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic [i2cms_pkg::OpW-1:0]   op_i,
  input  logic [i2cms_pkg::ByteW-1:0] write_byte_i,
  input  logic                       sda_in_i,
  output i2cms_pkg::res_t             res_o
);

  i2cms_pkg::kind_e                  kind_q, kind_d;
  logic [i2cms_pkg::PhaseW-1:0]      phase_q, phase_d;
  logic [i2cms_pkg::BitCntW-1:0]     bitcnt_q, bitcnt_d, bitcnt_inc;
  logic [i2cms_pkg::ByteW-1:0]       shift_q, shift_d, last_read_q, last_read_d;
  logic                              ack_q, ack_d, scl_q, scl_d, sda_q, sda_d;
  logic                              done, rejected, is_tick;

  // decode the command field, unused codes act as a tick
  always_comb begin
    is_tick = 1'b0;
    unique case (op_i)
      i2cms_pkg::OP_TICK:   is_tick = 1'b1;
      i2cms_pkg::OP_START,
      i2cms_pkg::OP_STOP,
      i2cms_pkg::OP_WRITE,
      i2cms_pkg::OP_RD_ACK,
      i2cms_pkg::OP_RD_NAK: is_tick = 1'b0;
      default:              is_tick = 1'b1;
    endcase
  end

  assign bitcnt_inc = bitcnt_q + 4'd1;

  // next state for one item
  always_comb begin
    kind_d      = kind_q;
    phase_d     = phase_q;
    bitcnt_d    = bitcnt_q;
    shift_d     = shift_q;
    ack_d       = ack_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    last_read_d = last_read_q;
    done        = 1'b0;
    rejected    = 1'b0;
    if (!is_tick) begin
      if (kind_q != i2cms_pkg::KIND_IDLE) begin
        rejected = 1'b1;
      end else begin
        kind_d   = i2cms_pkg::kind_e'(op_i);
        phase_d  = i2cms_pkg::PhaseLow;
        bitcnt_d = '0;
        if (op_i == i2cms_pkg::OP_START) begin
          sda_d = 1'b1;
          scl_d = 1'b1;
        end else if (op_i == i2cms_pkg::OP_STOP) begin
          scl_d = 1'b0;
          sda_d = 1'b0;
        end else if (op_i == i2cms_pkg::OP_WRITE) begin
          shift_d = write_byte_i;
          sda_d   = write_byte_i[i2cms_pkg::ByteW-1];
        end else begin
          shift_d = '0;
          sda_d   = 1'b1;
        end
      end
    end else begin
      unique case (kind_q)
        i2cms_pkg::KIND_IDLE: ;
        // start: sda falls, then scl falls
        i2cms_pkg::KIND_START: begin
          if (phase_q == i2cms_pkg::PhaseLow) begin
            sda_d   = 1'b0;
            phase_d = i2cms_pkg::PhaseHigh;
          end else begin
            scl_d = 1'b0;
            done  = 1'b1;
          end
        end
        // stop: scl rises, then sda rises, then one more period
        i2cms_pkg::KIND_STOP: begin
          if (phase_q == i2cms_pkg::PhaseLow) begin
            scl_d   = 1'b1;
            phase_d = i2cms_pkg::PhaseHigh;
          end else if (phase_q == i2cms_pkg::PhaseHigh) begin
            sda_d   = 1'b1;
            phase_d = i2cms_pkg::PhaseTail;
          end else begin
            done = 1'b1;
          end
        end
        // write: shift out msb first, sample ack on the ninth high phase
        i2cms_pkg::KIND_WRITE: begin
          if (phase_q == i2cms_pkg::PhaseLow) begin
            scl_d   = 1'b1;
            phase_d = i2cms_pkg::PhaseHigh;
          end else begin
            scl_d   = 1'b0;
            phase_d = i2cms_pkg::PhaseLow;
            if (bitcnt_q >= i2cms_pkg::LastBit) begin
              ack_d = ~sda_in_i;
              done  = 1'b1;
            end else begin
              bitcnt_d = bitcnt_inc;
              shift_d  = {shift_q[i2cms_pkg::ByteW-2:0], 1'b0};
              if (bitcnt_inc < i2cms_pkg::LastBit) begin
                sda_d = shift_q[i2cms_pkg::ByteW-2];
              end else begin
                sda_d = 1'b1;
              end
            end
          end
        end
        // read: shift in on each high phase, then drive ack or nak
        i2cms_pkg::KIND_RD_ACK,
        i2cms_pkg::KIND_RD_NAK: begin
          if (phase_q == i2cms_pkg::PhaseLow) begin
            scl_d   = 1'b1;
            phase_d = i2cms_pkg::PhaseHigh;
          end else begin
            scl_d   = 1'b0;
            phase_d = i2cms_pkg::PhaseLow;
            if (bitcnt_q >= i2cms_pkg::LastBit) begin
              last_read_d = shift_q;
              done        = 1'b1;
            end else begin
              shift_d  = {shift_q[i2cms_pkg::ByteW-2:0], sda_in_i};
              bitcnt_d = bitcnt_inc;
              if (bitcnt_inc == i2cms_pkg::LastBit) begin
                sda_d = (kind_q == i2cms_pkg::KIND_RD_NAK);
              end
            end
          end
        end
        default: ;
      endcase
      if (done) begin
        kind_d   = i2cms_pkg::KIND_IDLE;
        phase_d  = i2cms_pkg::PhaseLow;
        bitcnt_d = '0;
      end
    end
  end

  // state registers, advanced once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= i2cms_pkg::KIND_IDLE;
      phase_q     <= i2cms_pkg::PhaseLow;
      bitcnt_q    <= '0;
      shift_q     <= '0;
      ack_q       <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      last_read_q <= '0;
    end else if (load_i) begin
      kind_q      <= kind_d;
      phase_q     <= phase_d;
      bitcnt_q    <= bitcnt_d;
      shift_q     <= shift_d;
      ack_q       <= ack_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      last_read_q <= last_read_d;
    end
  end

  // result of this item, shows the state after it
  always_comb begin
    res_o.scl_out      = scl_d;
    res_o.sda_out      = sda_d;
    res_o.busy_res     = (kind_d != i2cms_pkg::KIND_IDLE);
    res_o.done_res     = done;
    res_o.ack_ok       = ack_d;
    res_o.read_byte    = last_read_d;
    res_o.cmd_rejected = rejected;
  end

endmodule

/* hdl/i2cms_out.sv */
// output register holding one result item until the sink takes it
// depends on i2cms_pkg
module i2cms_out (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  i2cms_pkg::res_t                  res_i,
  input  logic                            m_axis_tready,
  output logic                            m_axis_tvalid,
  output logic [i2cms_pkg::OutDataW-1:0]   m_axis_tdata
);

  logic            valid_q, valid_d;
  i2cms_pkg::res_t res_q;

  // valid is set by a new item and cleared when taken without a refill
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {{(i2cms_pkg::OutDataW - $bits(i2cms_pkg::res_t)){1'b0}}, res_q};

endmodule

/* hdl/i2c_master_byte_sequencer.sv */
// top level of the i2c master byte sequencer: stream ports, state core, output register
// depends on i2cms_pkg, i2cms_core and i2cms_out
//
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tuser op, tdata write_byte, sda_in
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata scl, sda, busy, done, ack, byte, rej
//
// the next state and the result are formed in one pass from the state registers and
// the accepted item, and the result is registered.
// one item is accepted per cycle while the output register is empty or being taken.
// after reset the sequencer is idle with scl and sda released and no result pending.
// a stall on m_axis holds the result and stops input only while the result waits.
module i2c_master_byte_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] write_byte, [8] sda_in, [15:9] zero
  input  logic [i2cms_pkg::InDataW-1:0]   s_axis_tdata,
  // [2:0] op
  input  logic [i2cms_pkg::OpW-1:0]       s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [4] ack_ok,
  // [12:5] read_byte, [13] cmd_rejected, [15:14] zero
  output logic [i2cms_pkg::OutDataW-1:0]  m_axis_tdata
);

  logic            load;
  i2cms_pkg::res_t res;

  // accept while the output register is free or drains this cycle
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign load          = s_axis_tvalid && s_axis_tready;

  i2cms_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .op_i         (s_axis_tuser),
    .write_byte_i (s_axis_tdata[i2cms_pkg::ByteW-1:0]),
    .sda_in_i     (s_axis_tdata[i2cms_pkg::ByteW]),
    .res_o        (res)
  );

  i2cms_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .res_i         (res),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

/* verif/i2c_master_byte_sequencer_tb.sv */
// self-checking testbench for the i2c master byte sequencer: directed and random command
// streams with random idling on both stream sides, results checked against a line-state predictor
// depends on i2cms_pkg and i2c_master_byte_sequencer
module i2c_master_byte_sequencer_tb;
  import i2cms_pkg::*;

  // undefined op codes, handled by the block as ticks
  localparam logic [OpW-1:0] OpSpare6 = 3'd6;
  localparam logic [OpW-1:0] OpSpare7 = 3'd7;
  localparam int unsigned ResW       = $bits(res_t);
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldLen    = 80;

  typedef struct {
    logic [OpW-1:0]   op;
    logic [ByteW-1:0] wb;
    logic             sd;
  } cmd_item_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [OpW-1:0]      s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  i2c_master_byte_sequencer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cmd_item_t   cmd_items_q[$];
  res_t        line_state_q[$];
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned res_cnt = 0;
  bit          offer_open = 1'b0;
  int unsigned tx_gap = 0;
  int unsigned rx_hold = 0;
  int unsigned next_hold_at = 150;

  // predicted sequencer state, reset values
  kind_e              bus_kind = KIND_IDLE;
  logic [PhaseW-1:0]  bus_phase = PhaseLow;
  logic [BitCntW-1:0] bus_bits = '0;
  logic [ByteW-1:0]   bus_shift = '0;
  logic               bus_ack = 1'b0;
  logic               bus_scl = 1'b1;
  logic               bus_sda = 1'b1;
  logic [ByteW-1:0]   bus_rd_byte = '0;

  // advance the predicted line state by one accepted item
  function automatic res_t predict_line_state(logic [OpW-1:0] op_raw, logic [ByteW-1:0] wb,
                                              logic sd);
    op_e  opc;
    logic rej;
    logic fin;
    res_t r;
    rej = 1'b0;
    fin = 1'b0;
    opc = (op_raw > OP_RD_NAK) ? OP_TICK : op_e'(op_raw);
    if (opc != OP_TICK) begin
      if (bus_kind != KIND_IDLE) begin
        rej = 1'b1;
      end else begin
        bus_kind  = kind_e'(opc);
        bus_phase = PhaseLow;
        bus_bits  = '0;
        case (opc)
          OP_START: begin
            bus_sda = 1'b1;
            bus_scl = 1'b1;
          end
          OP_STOP: begin
            bus_scl = 1'b0;
            bus_sda = 1'b0;
          end
          OP_WRITE: begin
            bus_shift = wb;
            bus_sda   = wb[ByteW-1];
          end
          default: begin
            bus_shift = '0;
            bus_sda   = 1'b1;
          end
        endcase
      end
    end else if (bus_kind != KIND_IDLE) begin
      case (bus_kind)
        KIND_START: begin
          if (bus_phase == PhaseLow) begin
            bus_sda   = 1'b0;
            bus_phase = PhaseHigh;
          end else begin
            bus_scl = 1'b0;
            fin     = 1'b1;
          end
        end
        KIND_STOP: begin
          if (bus_phase == PhaseLow) begin
            bus_scl   = 1'b1;
            bus_phase = PhaseHigh;
          end else if (bus_phase == PhaseHigh) begin
            bus_sda   = 1'b1;
            bus_phase = PhaseTail;
          end else begin
            fin = 1'b1;
          end
        end
        KIND_WRITE: begin
          if (bus_phase == PhaseLow) begin
            bus_scl   = 1'b1;
            bus_phase = PhaseHigh;
          end else begin
            bus_scl   = 1'b0;
            bus_phase = PhaseLow;
            if (bus_bits >= LastBit) begin
              // ack bit sampled at the end of the ninth high phase
              bus_ack = ~sd;
              fin     = 1'b1;
            end else begin
              bus_bits  = bus_bits + 1'b1;
              bus_shift = {bus_shift[ByteW-2:0], 1'b0};
              bus_sda   = (bus_bits < LastBit) ? bus_shift[ByteW-1] : 1'b1;
            end
          end
        end
        default: begin
          if (bus_phase == PhaseLow) begin
            bus_scl   = 1'b1;
            bus_phase = PhaseHigh;
          end else begin
            bus_scl   = 1'b0;
            bus_phase = PhaseLow;
            if (bus_bits >= LastBit) begin
              bus_rd_byte = bus_shift;
              fin         = 1'b1;
            end else begin
              bus_shift = {bus_shift[ByteW-2:0], sd};
              bus_bits  = bus_bits + 1'b1;
              // answer ack or nak after the eighth bit
              if (bus_bits == LastBit) bus_sda = (bus_kind == KIND_RD_ACK) ? 1'b0 : 1'b1;
            end
          end
        end
      endcase
      if (fin) begin
        bus_kind  = KIND_IDLE;
        bus_phase = PhaseLow;
        bus_bits  = '0;
      end
    end
    r.scl_out      = bus_scl;
    r.sda_out      = bus_sda;
    r.busy_res     = (bus_kind != KIND_IDLE);
    r.done_res     = fin;
    r.ack_ok       = bus_ack;
    r.read_byte    = bus_rd_byte;
    r.cmd_rejected = rej;
    return r;
  endfunction

  // idle length: mostly none, some short, a few long; quiet windows have none
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (cycle_cnt[10:9] == 2'b01) return 0;
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  function automatic logic [ByteW-1:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return ByteW'($urandom_range(0, 255));
  endfunction

  task automatic push_item(logic [OpW-1:0] op, logic [ByteW-1:0] wb, logic sd);
    cmd_item_t it;
    it.op = op;
    it.wb = wb;
    it.sd = sd;
    cmd_items_q.push_back(it);
  endtask

  // one command and its ticks; noise_pct inserts rejected commands, cut drops trailing ticks
  task automatic push_sequence(op_e cmd, logic [ByteW-1:0] wb, int noise_pct, int cut);
    int n;
    case (cmd)
      OP_START: n = 2;
      OP_STOP:  n = 3;
      default:  n = 18;
    endcase
    push_item(cmd, wb, 1'($urandom_range(0, 1)));
    for (int i = 0; i < n - cut; i++) begin
      if ($urandom_range(0, 99) < noise_pct)
        push_item(OpW'($urandom_range(OP_START, OP_RD_NAK)), pick_byte(),
                  1'($urandom_range(0, 1)));
      push_item(($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) == 0) ? OpSpare6 : OpSpare7)
                                            : OP_TICK,
                ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  // cycle counter and run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("i2c_master_byte_sequencer_tb failed");
      $finish;
    end
  end

  // input side: offer items from the pending queue at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && !offer_open) begin
      if (tx_gap > 0) begin
        tx_gap = tx_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_items_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd_items_q[0].op;
        s_axis_tdata  <= {{(InDataW-ByteW-1){1'b0}}, cmd_items_q[0].sd, cmd_items_q[0].wb};
        offer_open = 1'b1;
        tx_gap     = pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // input side: predict on every accepted item
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      line_state_q.push_back(predict_line_state(cmd_items_q[0].op, cmd_items_q[0].wb,
                                                cmd_items_q[0].sd));
      void'(cmd_items_q.pop_front());
      offer_open = 1'b0;
    end
  end

  // output side: random stalls plus a long hold every few hundred results
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (res_cnt >= next_hold_at) begin
        next_hold_at = next_hold_at + 200;
        rx_hold      = HoldLen;
      end else begin
        rx_hold = pick_gap();
      end
      m_axis_tready <= (rx_hold == 0);
    end
  end

  task automatic report_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      err_cnt = err_cnt + 1;
      if (err_cnt <= 10)
        $display("mismatch on result %0d, %s: expected %0h, got %0h", res_cnt, name, exp_v,
                 act_v);
    end
  endtask

  // output side: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    res_t exp_r;
    res_t act_r;
    if (m_axis_tvalid && m_axis_tready) begin
      act_r = res_t'(m_axis_tdata[ResW-1:0]);
      if (line_state_q.size() == 0) begin
        err_cnt = err_cnt + 1;
        if (err_cnt <= 10) $display("unexpected result, data %0h", m_axis_tdata);
      end else begin
        exp_r = line_state_q.pop_front();
        report_field("scl_out", exp_r.scl_out, act_r.scl_out);
        report_field("sda_out", exp_r.sda_out, act_r.sda_out);
        report_field("busy_res", exp_r.busy_res, act_r.busy_res);
        report_field("done_res", exp_r.done_res, act_r.done_res);
        report_field("ack_ok", exp_r.ack_ok, act_r.ack_ok);
        report_field("read_byte", exp_r.read_byte, act_r.read_byte);
        report_field("cmd_rejected", exp_r.cmd_rejected, act_r.cmd_rejected);
        report_field("pad", 0, m_axis_tdata[OutDataW-1:ResW]);
      end
      res_cnt = res_cnt + 1;
    end
  end

  // stimulus, reset and end of run
  initial begin
    int r;
    // idle ticks, including the undefined op codes
    push_item(OP_TICK, 8'h00, 1'b0);
    push_item(OpSpare6, 8'hFF, 1'b1);
    push_item(OpSpare7, 8'h00, 1'b1);
    // start with a write rejected while busy
    push_item(OP_START, 8'h00, 1'b0);
    push_item(OP_WRITE, 8'hA5, 1'b0);
    push_item(OP_TICK, 8'hFF, 1'b1);
    push_item(OP_TICK, 8'h00, 1'b0);
    // stop with a read rejected and a spare op acting as tick
    push_item(OP_STOP, 8'hFF, 1'b1);
    push_item(OP_RD_ACK, 8'h00, 1'b1);
    push_item(OpSpare6, 8'h00, 1'b0);
    push_item(OP_TICK, 8'h00, 1'b1);
    push_item(OP_TICK, 8'hFF, 1'b0);
    // write of all ones with scl still released
    push_sequence(OP_WRITE, 8'hFF, 0, 0);

    // random part: mostly complete commands, some cut short, some idle noise
    while (cmd_items_q.size() < 530) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        push_sequence(op_e'(OpW'($urandom_range(OP_START, OP_RD_NAK))), pick_byte(), 8, 0);
      end else if (r < 90) begin
        push_sequence(op_e'(OpW'($urandom_range(OP_START, OP_RD_NAK))), pick_byte(), 20,
                      $urandom_range(1, 2));
      end else begin
        repeat ($urandom_range(1, 3))
          push_item(($urandom_range(0, 3) == 0) ? OpSpare7 : OP_TICK,
                    ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_items_q.size() != 0 || line_state_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("i2c_master_byte_sequencer_tb passed");
    end else begin
      $display("i2c_master_byte_sequencer_tb failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/i2cms_pkg.sv
hdl/i2cms_core.sv
hdl/i2cms_out.sv
hdl/i2c_master_byte_sequencer.sv
verif/i2c_master_byte_sequencer_tb.sv
